@@ rtl/bqc_pkg.sv @@
// shared types and constants of the biquad cascade equalizer
`default_nettype none

package bqc_pkg;

   localparam int MAX_BANDS   = 8;
   localparam int SAMPLE_BITS = 24;
   localparam int COEF_BITS   = 24;

   localparam int FRAC_SHIFT  = COEF_BITS - 4;
   localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_BITS    = PROD_BITS + 3;
   localparam int COEF_COUNT  = 5;
   localparam int BAND_W      = 3;
   localparam int SEL_W       = 3;
   localparam int CFG_W       = 4;

   // commands
   localparam logic CMD_FILTER = 1'b0;
   localparam logic CMD_COEF   = 1'b1;

   // coefficient selectors
   localparam logic [SEL_W-1:0] COEF_B0 = 3'd0;
   localparam logic [SEL_W-1:0] COEF_B1 = 3'd1;
   localparam logic [SEL_W-1:0] COEF_B2 = 3'd2;
   localparam logic [SEL_W-1:0] COEF_A1 = 3'd3;
   localparam logic [SEL_W-1:0] COEF_A2 = 3'd4;

   // band cell sequence
   localparam int PHASE_BITS = 3;
   localparam logic [PHASE_BITS-1:0] PHASE_FIRST    = PHASE_BITS'(1);
   localparam logic [PHASE_BITS-1:0] PHASE_LAST_MUL = PHASE_BITS'(COEF_COUNT - 1);
   localparam logic [PHASE_BITS-1:0] PHASE_LAST_ACC = PHASE_BITS'(COEF_COUNT);
   localparam logic [PHASE_BITS-1:0] PHASE_ROUND    = PHASE_BITS'(COEF_COUNT + 1);

   typedef struct packed {
      logic                          command;
      logic signed [SAMPLE_BITS-1:0] sample_in;
      logic                          last_in_block;
      logic [BAND_W-1:0]             band_index;
      logic [SEL_W-1:0]              coef_select;
      logic signed [COEF_BITS-1:0]   coef_value;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_out;
      logic                          saturated;
      logic                          last_out;
   } rsp_type;

   // sample handed from one band cell to the next
   typedef struct packed {
      logic                          valid;
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          sat;
   } link_type;

   typedef struct packed {
      logic                        we;
      logic [SEL_W-1:0]            sel;
      logic signed [COEF_BITS-1:0] value;
   } coef_wr_type;

endpackage

`default_nettype wire

@@ rtl/bqc_cell.sv @@
// one direct form I biquad section with its own coefficients, history and multiplier
`default_nettype none

module bqc_cell import bqc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  link_type    link_in,
   input  logic        band_en,
   input  coef_wr_type coef_wr,
   output link_type    link_out
);

   localparam logic signed [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1) << (FRAC_SHIFT - 1);
   localparam logic signed [ACC_BITS-1:0] ACC_SMAX =
      (ACC_BITS'(1) << (SAMPLE_BITS - 1)) - ACC_BITS'(1);
   localparam logic signed [ACC_BITS-1:0] ACC_SMIN = -ACC_SMAX - ACC_BITS'(1);
   localparam logic signed [SAMPLE_BITS-1:0] SMAX = ACC_SMAX[SAMPLE_BITS-1:0];
   localparam logic signed [SAMPLE_BITS-1:0] SMIN = ACC_SMIN[SAMPLE_BITS-1:0];

   logic signed [COEF_BITS-1:0]   coef_ff [COEF_COUNT];
   logic signed [COEF_BITS-1:0]   coef_in [COEF_COUNT];
   logic signed [SAMPLE_BITS-1:0] x1_ff, x1_in, x2_ff, x2_in;
   logic signed [SAMPLE_BITS-1:0] y1_ff, y1_in, y2_ff, y2_in;
   logic                          run_ff, run_in;
   logic [PHASE_BITS-1:0]         phase_ff, phase_in;
   logic signed [PROD_BITS-1:0]   prod_ff, prod_in;
   logic                          neg_ff, neg_in;
   logic signed [ACC_BITS-1:0]    acc_ff, acc_in;
   logic signed [SAMPLE_BITS-1:0] x_cur_ff, x_cur_in;
   logic                          sat_cur_ff, sat_cur_in;
   link_type                      out_ff, out_in;

   logic [SEL_W-1:0]              mul_sel;
   logic signed [COEF_BITS-1:0]   mul_coef;
   logic signed [SAMPLE_BITS-1:0] mul_op;
   logic signed [PROD_BITS-1:0]   product;
   logic signed [ACC_BITS-1:0]    prod_ext;
   logic signed [ACC_BITS-1:0]    acc_sum;
   logic signed [ACC_BITS-1:0]    rounded;
   logic signed [SAMPLE_BITS-1:0] y_sat;
   logic                          clip;

   // operand select for the shared multiplier: b0*x on the start cycle
   always_comb begin
      mul_sel = link_in.valid ? COEF_B0 : phase_ff;
      case (mul_sel)
         COEF_B0: begin
            mul_coef = coef_ff[COEF_B0];
            mul_op   = link_in.sample;
         end
         COEF_B1: begin
            mul_coef = coef_ff[COEF_B1];
            mul_op   = x1_ff;
         end
         COEF_B2: begin
            mul_coef = coef_ff[COEF_B2];
            mul_op   = x2_ff;
         end
         COEF_A1: begin
            mul_coef = coef_ff[COEF_A1];
            mul_op   = y1_ff;
         end
         default: begin
            mul_coef = coef_ff[COEF_A2];
            mul_op   = y2_ff;
         end
      endcase
   end

   assign product  = mul_coef * mul_op;
   assign prod_ext = ACC_BITS'(prod_ff);
   assign acc_sum  = neg_ff ? (acc_ff - prod_ext) : (acc_ff + prod_ext);

   // round half up then clip to the sample range
   assign rounded = (acc_ff + ROUND_HALF) >>> FRAC_SHIFT;
   always_comb begin
      clip = 1'b0;
      if (rounded > ACC_SMAX) begin
         y_sat = SMAX;
         clip  = 1'b1;
      end else if (rounded < ACC_SMIN) begin
         y_sat = SMIN;
         clip  = 1'b1;
      end else begin
         y_sat = rounded[SAMPLE_BITS-1:0];
      end
   end

   always_comb begin
      coef_in    = coef_ff;
      x1_in      = x1_ff;
      x2_in      = x2_ff;
      y1_in      = y1_ff;
      y2_in      = y2_ff;
      run_in     = run_ff;
      phase_in   = phase_ff;
      prod_in    = prod_ff;
      neg_in     = neg_ff;
      acc_in     = acc_ff;
      x_cur_in   = x_cur_ff;
      sat_cur_in = sat_cur_ff;
      out_in     = out_ff;
      out_in.valid = 1'b0;

      if (coef_wr.we) begin
         coef_in[coef_wr.sel] = coef_wr.value;
      end

      if (link_in.valid) begin
         if (band_en) begin
            run_in     = 1'b1;
            phase_in   = PHASE_FIRST;
            prod_in    = product;
            neg_in     = 1'b0;
            acc_in     = '0;
            x_cur_in   = link_in.sample;
            sat_cur_in = link_in.sat;
         end else begin
            // idle band: hand the item on untouched
            out_in = link_in;
         end
      end else if (run_ff) begin
         phase_in = phase_ff + PHASE_BITS'(1);
         if (phase_ff <= PHASE_LAST_MUL) begin
            prod_in = product;
            neg_in  = (phase_ff >= COEF_A1);
         end
         if (phase_ff <= PHASE_LAST_ACC) begin
            acc_in = acc_sum;
         end
         if (phase_ff == PHASE_ROUND) begin
            run_in       = 1'b0;
            x2_in        = x1_ff;
            x1_in        = x_cur_ff;
            y2_in        = y1_ff;
            y1_in        = y_sat;
            out_in.valid = 1'b1;
            out_in.sample = y_sat;
            out_in.sat   = sat_cur_ff | clip;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < COEF_COUNT; i++) begin
            coef_ff[i] <= '0;
         end
         x1_ff        <= '0;
         x2_ff        <= '0;
         y1_ff        <= '0;
         y2_ff        <= '0;
         run_ff       <= 1'b0;
         phase_ff     <= '0;
         out_ff.valid <= 1'b0;
      end else begin
         coef_ff      <= coef_in;
         x1_ff        <= x1_in;
         x2_ff        <= x2_in;
         y1_ff        <= y1_in;
         y2_ff        <= y2_in;
         run_ff       <= run_in;
         phase_ff     <= phase_in;
         out_ff       <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff       <= prod_in;
      neg_ff        <= neg_in;
      acc_ff        <= acc_in;
      x_cur_ff      <= x_cur_in;
      sat_cur_ff    <= sat_cur_in;
   end

   assign link_out = out_ff;

endmodule

`default_nettype wire

@@ rtl/biquad_cascade_equalizer_top.sv @@
// top level of the biquad cascade equalizer: request decode, band cell chain, result buffer
// path: a sample item passes the band cells in turn and then the output register;
//   each applied band cell runs its one multiplier over five coefficients and then rounds,
//   and an idle cell passes the item on through its output register
// flow: one sample at a time, as a new request is taken only once the last result has
//   moved into the output register; a coefficient item gives no result and sets no busy
// reset: synchronous, clears band count, coefficients and history at once
`default_nettype none

module biquad_cascade_equalizer_top import bqc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CFG_W-1:0] csr_data
);

   logic [CFG_W-1:0] active_bands_ff, active_bands_in;
   logic             busy_ff, busy_in;
   logic             last_ff, last_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic             hold_valid_ff, hold_valid_in;
   rsp_type          hold_ff, hold_in;

   logic             accept;
   logic             sample_go;
   logic             coef_ok;
   logic             out_free;
   rsp_type          chain_rsp;
   link_type         chain [MAX_BANDS+1];
   coef_wr_type      coef_bus [MAX_BANDS];
   logic [MAX_BANDS-1:0] band_en;
   logic [MAX_BANDS:0]   pulse_vec;

   assign req_ready = ~busy_ff;
   assign csr_ready = 1'b1;
   assign accept    = req_valid & req_ready;
   assign sample_go = accept & (req_data.command == CMD_FILTER);
   assign coef_ok   = accept & (req_data.command == CMD_COEF)
                    & (32'(req_data.band_index) < MAX_BANDS)
                    & (32'(req_data.coef_select) < COEF_COUNT);

   assign chain[0].valid  = sample_go;
   assign chain[0].sample = req_data.sample_in;
   assign chain[0].sat    = 1'b0;

   always_comb begin
      for (int b = 0; b < MAX_BANDS; b++) begin
         coef_bus[b].we    = coef_ok & (32'(req_data.band_index) == b);
         coef_bus[b].sel   = req_data.coef_select;
         coef_bus[b].value = req_data.coef_value;
         // a count above the number of bands simply enables them all
         band_en[b]        = 32'(active_bands_ff) > b;
      end
      for (int b = 0; b <= MAX_BANDS; b++) begin
         pulse_vec[b] = chain[b].valid;
      end
   end

   for (genvar g = 0; g < MAX_BANDS; g++) begin : g_band
      bqc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .link_in  (chain[g]),
         .band_en  (band_en[g]),
         .coef_wr  (coef_bus[g]),
         .link_out (chain[g+1])
      );
   end

   assign chain_rsp.sample_out = chain[MAX_BANDS].sample;
   assign chain_rsp.saturated  = chain[MAX_BANDS].sat;
   assign chain_rsp.last_out   = last_ff;

   assign out_free = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      active_bands_in = active_bands_ff;
      busy_in         = busy_ff;
      last_in         = last_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_in          = rsp_ff;
      hold_valid_in   = hold_valid_ff;
      hold_in         = hold_ff;

      if (csr_valid & csr_ready) begin
         active_bands_in = csr_data;
      end
      if (sample_go) begin
         busy_in = 1'b1;
         last_in = req_data.last_in_block;
      end
      if (rsp_valid_ff & rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      // a finished item waits in the hold register while the output is stalled
      if (hold_valid_ff & out_free) begin
         rsp_in        = hold_ff;
         rsp_valid_in  = 1'b1;
         hold_valid_in = 1'b0;
         busy_in       = 1'b0;
      end else if (chain[MAX_BANDS].valid) begin
         if (out_free) begin
            rsp_in       = chain_rsp;
            rsp_valid_in = 1'b1;
            busy_in      = 1'b0;
         end else begin
            hold_in       = chain_rsp;
            hold_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_bands_ff <= '0;
         busy_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         hold_valid_ff   <= 1'b0;
      end else begin
         active_bands_ff <= active_bands_in;
         busy_ff         <= busy_in;
         rsp_valid_ff    <= rsp_valid_in;
         hold_valid_ff   <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
      rsp_ff  <= rsp_in;
      hold_ff <= hold_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // only one item moves along the chain at a time
   a_one_link: assert property (@(posedge clock) disable iff (reset)
      $onehot0(pulse_vec))
      else $error("more than one item on the band chain");

   // the hold register is only used behind a full output register
   a_hold_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> rsp_valid_ff)
      else $error("hold register full with output register empty");

   // the chain only finishes an item that was taken
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      chain[MAX_BANDS].valid |-> busy_ff)
      else $error("chain result without an item in flight");

   // a taken sample keeps the block busy
   a_busy_after_go: assert property (@(posedge clock) disable iff (reset)
      sample_go |=> busy_ff)
      else $error("sample taken but block not busy");

endmodule

`default_nettype wire
